FILE: src/bfpa_pkg.sv
package bfpa_pkg;

  localparam int FREE_ENTRIES = 16;
  localparam int USED_ENTRIES = 16;
  localparam int ADDR_BITS    = 24;
  localparam int SIZE_BITS    = ADDR_BITS + 1;
  localparam int FIDX_BITS    = $clog2(FREE_ENTRIES);
  localparam int UIDX_BITS    = $clog2(USED_ENTRIES);

  localparam logic [1:0] KIND_ALLOC   = 2'd0;
  localparam logic [1:0] KIND_RECLAIM = 2'd1;
  localparam logic [1:0] KIND_RELOAD  = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NOFIT    = 3'd1;
  localparam logic [2:0] ST_USEDFULL = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_FREEFULL = 3'd4;

  localparam logic [1:0] REG_POOL_BASE = 2'd0;
  localparam logic [1:0] REG_POOL_SIZE = 2'd1;
  localparam logic [1:0] REG_MIN_FRAG  = 2'd2;

  typedef struct packed {
    logic [1:0]           kind;
    logic [7:0]           job_id;
    logic [ADDR_BITS-1:0] request_length;
  } in_item_t;

  typedef struct packed {
    logic [2:0]           status;
    logic [ADDR_BITS-1:0] region_address;
    logic [SIZE_BITS-1:0] region_length;
  } out_item_t;

  typedef struct packed {
    logic                 valid;
    logic [ADDR_BITS-1:0] start;
    logic [SIZE_BITS-1:0] size;
  } free_ent_t;

  typedef struct packed {
    logic [7:0]           job;
    logic [ADDR_BITS-1:0] start;
    logic [SIZE_BITS-1:0] size;
  } used_ent_t;

  // command to every cell of a ring
  typedef enum logic [2:0] {
    RC_HOLD, RC_ROTATE, RC_RELOAD, RC_WRITE
  } ring_cmd_e;

  typedef struct packed {
    ring_cmd_e cmd;
    free_ent_t wdata;
  } free_ctl_t;

  typedef struct packed {
    ring_cmd_e cmd;
    used_ent_t wdata;
  } used_ctl_t;

  typedef enum logic [3:0] {
    S_IDLE, S_FIT, S_USCAN, S_ACOMMIT, S_RFIND, S_RNBR, S_RSLOT,
    S_RCOMMIT, S_DONE
  } state_e;

endpackage

FILE: src/best_fit_partition_allocator_unit.sv
// An allocate finds the best fit, turns the free ring to it, finds an empty used slot
// and commits; a reclaim finds the job, merges with free neighbours or takes an empty
// free slot, and commits; reload and unused kinds go straight to the result. One item
// at a time; busy may stay high after the result while the rings turn home. Synchronous
// active-low reset loads the free table from the pool registers and clears the used
// table. The tables are rings of cells; results are strobed for one cycle, no stall.
module best_fit_partition_allocator_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  bfpa_pkg::in_item_t   in_item,
  output logic                 out_valid,
  output bfpa_pkg::out_item_t  out_item,
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic [3:0]           cfg_paddr,
  input  logic [31:0]          cfg_pwdata,
  output logic [31:0]          cfg_prdata,
  output logic                 cfg_pready
);
  localparam int AB = bfpa_pkg::ADDR_BITS;
  localparam int SB = bfpa_pkg::SIZE_BITS;
  localparam int FN = bfpa_pkg::FREE_ENTRIES;
  localparam int UN = bfpa_pkg::USED_ENTRIES;
  localparam int FB = bfpa_pkg::FIDX_BITS;
  localparam int UB = bfpa_pkg::UIDX_BITS;

  logic [AB-1:0] pool_base_r;
  logic [SB-1:0] pool_size_r;
  logic [15:0]   min_frag_r;

  assign cfg_pready = 1'b1;
  wire cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_base_r <= AB'(10240);
      pool_size_r <= SB'(102400);
      min_frag_r  <= 16'd100;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        bfpa_pkg::REG_POOL_BASE: pool_base_r <= cfg_pwdata[AB-1:0];
        bfpa_pkg::REG_POOL_SIZE: pool_size_r <= cfg_pwdata[SB-1:0];
        bfpa_pkg::REG_MIN_FRAG:  min_frag_r  <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      bfpa_pkg::REG_POOL_BASE: cfg_prdata = 32'(pool_base_r);
      bfpa_pkg::REG_POOL_SIZE: cfg_prdata = 32'(pool_size_r);
      bfpa_pkg::REG_MIN_FRAG:  cfg_prdata = 32'(min_frag_r);
      default:                 cfg_prdata = '0;
    endcase
  end

  // ring of cells; head is cell 0, cell i takes from cell i+1
  bfpa_pkg::free_ctl_t fctl;
  bfpa_pkg::used_ctl_t uctl;
  bfpa_pkg::free_ent_t fent [FN];
  bfpa_pkg::used_ent_t uent [UN];

  for (genvar g = 0; g < FN; g++) begin : g_free
    bfpa_pkg::free_ent_t init;
    assign init = (g == 0)
      ? bfpa_pkg::free_ent_t'{valid: 1'b1, start: pool_base_r, size: pool_size_r}
      : '0;
    bfpa_free_cell u_cell (
      .clk(clk), .ctl(fctl), .head(g == 0), .init_ent(init),
      .from_prev(fent[(g + 1) % FN]), .ent(fent[g])
    );
  end
  for (genvar g = 0; g < UN; g++) begin : g_used
    bfpa_used_cell u_cell (
      .clk(clk), .ctl(uctl), .head(g == 0),
      .from_prev(uent[(g + 1) % UN]), .ent(uent[g])
    );
  end

  // head index: position of the entry now in cell 0
  bfpa_pkg::state_e st_r, st_nxt;
  logic [FB:0] fcnt_r, fcnt_nxt;
  logic [UB:0] ucnt_r, ucnt_nxt;
  logic [1:0]  pass_r, pass_nxt;
  bfpa_pkg::in_item_t  req_r, req_nxt;
  bfpa_pkg::out_item_t res_r, res_nxt;
  logic out_v_r, out_v_nxt;
  logic          best_ok_r, best_ok_nxt;
  logic [FB-1:0] best_r, best_nxt;
  logic [SB-1:0] best_sz_r, best_sz_nxt;
  logic          slot_ok_r, slot_ok_nxt;
  logic [UB-1:0] slot_r, slot_nxt;
  logic          lo_ok_r, lo_ok_nxt, up_ok_r, up_ok_nxt;
  logic [FB-1:0] lo_r, lo_nxt, up_r, up_nxt;
  logic [SB-1:0] up_sz_r, up_sz_nxt;
  logic [AB-1:0] sa_r, sa_nxt;
  logic [SB-1:0] sl_r, sl_nxt;

  wire [FB-1:0] fidx = fcnt_r[FB-1:0];
  wire [UB-1:0] uidx = ucnt_r[UB-1:0];
  wire f_last = (fcnt_r == (FB+1)'(FN - 1));
  wire u_last = (ucnt_r == (UB+1)'(UN - 1));
  wire ring_home = (fcnt_r == '0) && (ucnt_r == '0);
  bfpa_pkg::free_ent_t fh;
  bfpa_pkg::used_ent_t uh;
  assign fh = fent[0];
  assign uh = uent[0];

  logic [SB-1:0] rem;
  logic [AB+1:0] fend;
  logic [AB+1:0] send;
  assign rem  = best_sz_r - SB'(req_r.request_length);
  assign fend = {2'b0, fh.start} + {1'b0, fh.size};
  assign send = {2'b0, sa_r} + {1'b0, sl_r};

  always_comb begin
    st_nxt = st_r; fcnt_nxt = fcnt_r; ucnt_nxt = ucnt_r; pass_nxt = pass_r;
    req_nxt = req_r; res_nxt = res_r; out_v_nxt = 1'b0;
    best_ok_nxt = best_ok_r; best_nxt = best_r; best_sz_nxt = best_sz_r;
    slot_ok_nxt = slot_ok_r; slot_nxt = slot_r;
    lo_ok_nxt = lo_ok_r; lo_nxt = lo_r; up_ok_nxt = up_ok_r; up_nxt = up_r;
    up_sz_nxt = up_sz_r; sa_nxt = sa_r; sl_nxt = sl_r;
    fctl = '{cmd: bfpa_pkg::RC_HOLD, wdata: fh};
    uctl = '{cmd: bfpa_pkg::RC_HOLD, wdata: uh};
    unique case (st_r)
      bfpa_pkg::S_IDLE: begin
        if (start && ring_home) begin
          req_nxt = in_item; fcnt_nxt = '0; ucnt_nxt = '0; pass_nxt = '0;
          best_ok_nxt = 1'b0; slot_ok_nxt = 1'b0; lo_ok_nxt = 1'b0; up_ok_nxt = 1'b0;
          unique case (in_item.kind)
            bfpa_pkg::KIND_ALLOC:   st_nxt = bfpa_pkg::S_FIT;
            bfpa_pkg::KIND_RECLAIM: st_nxt = bfpa_pkg::S_RFIND;
            bfpa_pkg::KIND_RELOAD: begin
              fctl.cmd = bfpa_pkg::RC_RELOAD; uctl.cmd = bfpa_pkg::RC_RELOAD;
              res_nxt = '{bfpa_pkg::ST_OK, pool_base_r, pool_size_r};
              st_nxt = bfpa_pkg::S_DONE;
            end
            default: begin
              res_nxt = '{bfpa_pkg::ST_OK, '0, '0};
              st_nxt = bfpa_pkg::S_DONE;
            end
          endcase
        end else begin
          // turn each ring back until entry 0 sits in the head cell
          if (fcnt_r != '0) begin
            fctl.cmd = bfpa_pkg::RC_ROTATE;
            fcnt_nxt = f_last ? '0 : fcnt_r + 1'b1;
          end
          if (ucnt_r != '0) begin
            uctl.cmd = bfpa_pkg::RC_ROTATE;
            ucnt_nxt = u_last ? '0 : ucnt_r + 1'b1;
          end
        end
      end
      bfpa_pkg::S_FIT: begin
        // pass 0: find best; pass 1: rotate to best and hold it there for the commit
        fctl.cmd = bfpa_pkg::RC_ROTATE;
        if (pass_r == 2'd0) begin
          if (fh.valid && fh.size >= SB'(req_r.request_length) &&
              (!best_ok_r || fh.size < best_sz_r)) begin
            best_ok_nxt = 1'b1; best_nxt = fidx; best_sz_nxt = fh.size;
          end
          fcnt_nxt = fcnt_r + 1'b1;
          if (f_last) begin
            fcnt_nxt = '0;
            if (!(best_ok_nxt)) begin
              res_nxt = '{bfpa_pkg::ST_NOFIT, '0, '0};
              st_nxt = bfpa_pkg::S_DONE;
            end else pass_nxt = 2'd1;
          end
        end else begin
          if (fidx == best_r) begin
            // hold ring at best for the commit
            fctl.cmd = bfpa_pkg::RC_HOLD;
            st_nxt = bfpa_pkg::S_USCAN;
          end else fcnt_nxt = fcnt_r + 1'b1;
        end
      end
      bfpa_pkg::S_USCAN: begin
        uctl.cmd = bfpa_pkg::RC_ROTATE;
        if (!slot_ok_r && uh.job == 8'd0) begin
          slot_ok_nxt = 1'b1; slot_nxt = uidx;
        end
        ucnt_nxt = ucnt_r + 1'b1;
        if (slot_ok_r && uidx == slot_r) begin
          uctl.cmd = bfpa_pkg::RC_HOLD; ucnt_nxt = ucnt_r;
          st_nxt = bfpa_pkg::S_ACOMMIT;
        end else if (u_last) begin
          ucnt_nxt = '0;
          if (!slot_ok_nxt) begin
            res_nxt = '{bfpa_pkg::ST_USEDFULL, '0, '0};
            st_nxt = bfpa_pkg::S_DONE;
          end
        end
      end
      bfpa_pkg::S_ACOMMIT: begin
        fctl.cmd = bfpa_pkg::RC_WRITE; uctl.cmd = bfpa_pkg::RC_WRITE;
        if (rem <= SB'(min_frag_r)) begin
          fctl.wdata.valid = 1'b0;
          uctl.wdata = '{req_r.job_id, fh.start, fh.size};
          res_nxt = '{bfpa_pkg::ST_OK, fh.start, fh.size};
        end else begin
          fctl.wdata.size = rem;
          uctl.wdata = '{req_r.job_id, fh.start + rem[AB-1:0],
                         SB'(req_r.request_length)};
          res_nxt = '{bfpa_pkg::ST_OK, fh.start + rem[AB-1:0],
                      SB'(req_r.request_length)};
        end
        st_nxt = bfpa_pkg::S_DONE;
      end
      bfpa_pkg::S_RFIND: begin
        uctl.cmd = bfpa_pkg::RC_ROTATE;
        if (req_r.job_id != 8'd0 && uh.job == req_r.job_id) begin
          uctl.cmd = bfpa_pkg::RC_HOLD;
          sa_nxt = uh.start; sl_nxt = uh.size;
          st_nxt = bfpa_pkg::S_RNBR;
        end else begin
          ucnt_nxt = ucnt_r + 1'b1;
          if (u_last) begin
            ucnt_nxt = '0;
            res_nxt = '{bfpa_pkg::ST_NOTFOUND, '0, '0};
            st_nxt = bfpa_pkg::S_DONE;
          end
        end
      end
      bfpa_pkg::S_RNBR: begin
        // pass 0 search; pass 1 go to up (when merging both, invalidate up);
        // pass 2 go to lo or up and write
        fctl.cmd = bfpa_pkg::RC_ROTATE;
        fcnt_nxt = fcnt_r + 1'b1;
        if (f_last) fcnt_nxt = '0;
        unique case (pass_r)
          2'd0: begin
            if (!(lo_ok_r && up_ok_r) && fh.valid) begin
              if (fend == {2'b0, sa_r}) begin lo_ok_nxt = 1'b1; lo_nxt = fidx; end
              else if ({2'b0, fh.start} == send) begin
                up_ok_nxt = 1'b1; up_nxt = fidx; up_sz_nxt = fh.size;
              end
            end
            if (f_last) begin
              if (lo_ok_nxt && up_ok_nxt) pass_nxt = 2'd1;
              else if (lo_ok_nxt || up_ok_nxt) pass_nxt = 2'd2;
              else st_nxt = bfpa_pkg::S_RSLOT;
            end
          end
          2'd1: if (fidx == up_r) begin
            fctl.cmd = bfpa_pkg::RC_WRITE; fctl.wdata.valid = 1'b0;
            fcnt_nxt = fcnt_r; pass_nxt = 2'd2;
          end
          default: if (fidx == (lo_ok_r ? lo_r : up_r)) begin
            fctl.cmd = bfpa_pkg::RC_WRITE; fcnt_nxt = fcnt_r;
            if (lo_ok_r)
              fctl.wdata.size = fh.size + sl_r + (up_ok_r ? up_sz_r : '0);
            else begin
              fctl.wdata.start = sa_r; fctl.wdata.size = fh.size + sl_r;
            end
            st_nxt = bfpa_pkg::S_RCOMMIT;
          end
        endcase
      end
      bfpa_pkg::S_RSLOT: begin
        fctl.cmd = bfpa_pkg::RC_ROTATE;
        if (!fh.valid) begin
          fctl.cmd = bfpa_pkg::RC_WRITE;
          fctl.wdata = '{1'b1, sa_r, sl_r};
          st_nxt = bfpa_pkg::S_RCOMMIT;
        end else begin
          fcnt_nxt = fcnt_r + 1'b1;
          if (f_last) begin
            fcnt_nxt = '0;
            res_nxt = '{bfpa_pkg::ST_FREEFULL, '0, '0};
            st_nxt = bfpa_pkg::S_DONE;
          end
        end
      end
      bfpa_pkg::S_RCOMMIT: begin
        uctl.cmd = bfpa_pkg::RC_WRITE; uctl.wdata.job = 8'd0;
        res_nxt = '{bfpa_pkg::ST_OK, sa_r, sl_r};
        st_nxt = bfpa_pkg::S_DONE;
      end
      bfpa_pkg::S_DONE: begin
        out_v_nxt = 1'b1;
        st_nxt = bfpa_pkg::S_IDLE;
      end
      default: st_nxt = bfpa_pkg::S_IDLE;
    endcase
    if (!rst_n) begin
      fctl.cmd = bfpa_pkg::RC_RELOAD; uctl.cmd = bfpa_pkg::RC_RELOAD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= bfpa_pkg::S_IDLE; out_v_r <= 1'b0;
      fcnt_r <= '0; ucnt_r <= '0; pass_r <= '0;
    end else begin
      st_r <= st_nxt; out_v_r <= out_v_nxt;
      fcnt_r <= fcnt_nxt; ucnt_r <= ucnt_nxt; pass_r <= pass_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt; res_r <= res_nxt;
    best_ok_r <= best_ok_nxt; best_r <= best_nxt; best_sz_r <= best_sz_nxt;
    slot_ok_r <= slot_ok_nxt; slot_r <= slot_nxt;
    lo_ok_r <= lo_ok_nxt; lo_r <= lo_nxt; up_ok_r <= up_ok_nxt; up_r <= up_nxt;
    up_sz_r <= up_sz_nxt; sa_r <= sa_nxt; sl_r <= sl_nxt;
  end

  // the result strobe fires when leaving DONE
  assign busy      = (st_r != bfpa_pkg::S_IDLE) || !ring_home;
  assign out_valid = out_v_r;
  assign out_item  = res_r;

  a_strobe_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> $past(st_r) == bfpa_pkg::S_DONE) else $error("stray strobe");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> st_r == bfpa_pkg::S_IDLE) else $error("strobe while busy");
  a_commit_has_slot: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == bfpa_pkg::S_ACOMMIT |-> slot_ok_r && best_ok_r) else $error("bad commit");
  a_start_at_home: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ring_home) else $error("accept with rings away from home");
endmodule

FILE: src/bfpa_free_cell.sv
module bfpa_free_cell (
  input  logic                 clk,
  input  bfpa_pkg::free_ctl_t  ctl,
  input  logic                 head,
  input  bfpa_pkg::free_ent_t  init_ent,
  input  bfpa_pkg::free_ent_t  from_prev,
  output bfpa_pkg::free_ent_t  ent
);
  bfpa_pkg::free_ent_t ent_r, ent_nxt;

  always_comb begin
    ent_nxt = ent_r;
    unique case (ctl.cmd)
      bfpa_pkg::RC_ROTATE: ent_nxt = from_prev;
      bfpa_pkg::RC_RELOAD: ent_nxt = init_ent;
      bfpa_pkg::RC_WRITE:  if (head) ent_nxt = ctl.wdata;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign ent = ent_r;
endmodule

FILE: src/bfpa_used_cell.sv
module bfpa_used_cell (
  input  logic                 clk,
  input  bfpa_pkg::used_ctl_t  ctl,
  input  logic                 head,
  input  bfpa_pkg::used_ent_t  from_prev,
  output bfpa_pkg::used_ent_t  ent
);
  bfpa_pkg::used_ent_t ent_r, ent_nxt;

  always_comb begin
    ent_nxt = ent_r;
    unique case (ctl.cmd)
      bfpa_pkg::RC_ROTATE: ent_nxt = from_prev;
      bfpa_pkg::RC_RELOAD: ent_nxt = '0;
      bfpa_pkg::RC_WRITE:  if (head) ent_nxt = ctl.wdata;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign ent = ent_r;
endmodule
